// ===== hw/rtl/lruc_pkg.sv =====
// Shared constants, register codes and cell control type for the LRU cost counter.
package lruc_pkg;

  // Default build parameters.
  localparam int CAPACITY_DEF  = 32;
  localparam int KEY_CHARS_DEF = 8;

  // Fixed field widths.
  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 6;
  localparam int COST_W  = 8;
  localparam int TOTAL_W = 32;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 2;

  // Register indexes, taken from paddr[3:2].
  localparam logic [IDX_W-1:0] REG_CACHE_SIZE = 2'd0;
  localparam logic [IDX_W-1:0] REG_HIT_COST   = 2'd1;
  localparam logic [IDX_W-1:0] REG_MISS_COST  = 2'd2;

  // Register reset values.
  localparam logic [SIZE_W-1:0] CACHE_SIZE_RST = 6'd3;
  localparam logic [COST_W-1:0] HIT_COST_RST   = 8'd1;
  localparam logic [COST_W-1:0] MISS_COST_RST  = 8'd5;

  // Case folding of ASCII lower-case letters.
  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic upd;         // apply a lookup result this cycle
    logic sel_hit;     // the matching cell becomes most recent
    logic sel_free;    // the lowest invalid cell takes the key
    logic sel_victim;  // the cell whose rank equals the bound takes the key
    logic shrink;      // drop cells whose rank is at or above the bound
  } lruc_ctrl_t;

endpackage

// ===== hw/rtl/lruc_cell.sv =====
// One cache entry: stored key, valid bit and recency rank, with a free-slot chain link.
module lruc_cell import lruc_pkg::*; #(
  parameter int KW     = 64,
  parameter int RANK_W = 5,
  parameter int CNT_W  = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lruc_ctrl_t        ctrl_i,
  input  logic [KW-1:0]     key_i,
  input  logic [CNT_W-1:0]  bound_i,
  input  logic              free_i,
  output logic              free_o,
  output logic              match_o,
  output logic [RANK_W-1:0] rank_o
);

  logic              valid_q, valid_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic [KW-1:0]     key_q;
  logic [CNT_W-1:0]  rank_ext;
  logic              first_free;
  logic              victim;
  logic              target;

  assign rank_ext = CNT_W'(rank_q);

  // A free slot somewhere below this cell blocks it from being the fill target.
  assign free_o     = free_i | ~valid_q;
  assign first_free = ~valid_q & ~free_i;

  assign match_o = valid_q && (key_q == key_i);
  assign rank_o  = match_o ? rank_q : '0;
  assign victim  = valid_q && (rank_ext == bound_i);

  assign target = (ctrl_i.sel_hit & match_o) | (ctrl_i.sel_free & first_free) |
                  (ctrl_i.sel_victim & victim);

  // Rank and valid updates for lookups and for a cache-size shrink.
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (ctrl_i.shrink) begin
      if (valid_q && rank_ext >= bound_i) begin
        valid_d = 1'b0;
      end
    end else if (ctrl_i.upd) begin
      if (target) begin
        valid_d = 1'b1;
        rank_d  = '0;
      end else if (valid_q && rank_ext < bound_i) begin
        rank_d = rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  // The key store needs no reset; it is only compared while valid.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd && target) begin
      key_q <= key_i;
    end
  end

endmodule

// ===== hw/rtl/lru_cache_hit_cost_counter.sv =====
// Top level of the fully associative LRU cache cost counter built as a chain of entry cells.
//
//   Channel  Direction  Handshake                      Payload
//   in       input      in_valid_i / in_stall_o        key_i (64)
//   out      output     out_valid_o / out_stall_i      hit_o (1), total_cost_o (32)
//   cfg      input      APB psel/penable/pwrite/pready paddr (4), pwdata/prdata (32)
//
// An item passes through ST_IDLE, which takes in and case-folds the key, and ST_LOOKUP,
// in which every cell of the chain compares the key and updates its rank in parallel.
// The lookup cycle waits while a finished result is still held by out_stall_i; a new
// item is taken in while that result waits. Reset clears all valid bits and the running
// total at once; there is no clearing pass. Costs saturate at the 32-bit maximum.
module lru_cache_hit_cost_counter import lruc_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_CHARS = KEY_CHARS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KEY_W-1:0]   key_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [TOTAL_W-1:0] total_cost_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int KW     = 8 * KEY_CHARS;
  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int EXT_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  typedef enum logic {ST_IDLE, ST_LOOKUP} state_e;

  state_e             state_q;
  logic [KW-1:0]      key_q;
  logic [KW-1:0]      key_fold;
  logic               out_valid_q;
  logic               hit_q;
  logic [TOTAL_W-1:0] cost_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic [SIZE_W-1:0]  cache_size_q;
  logic [COST_W-1:0]  hit_cost_q;
  logic [COST_W-1:0]  miss_cost_q;

  logic               cfg_wr;
  logic [IDX_W-1:0]   cfg_idx;
  logic               size_wr;
  logic [EXT_W-1:0]   size_ext, new_ext;
  logic [CNT_W-1:0]   eff, eff_new;

  lruc_ctrl_t         ctrl;
  logic [CNT_W-1:0]   bound;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY:0]  free_chain;
  logic [RANK_W-1:0]  rank_vec [CAPACITY];
  logic [RANK_W-1:0]  hit_rank;
  logic               hit_any;
  logic               fire;
  logic [COST_W-1:0]  cost_add;
  logic [TOTAL_W:0]   cost_sum;
  logic [TOTAL_W-1:0] cost_next;

  // Case-fold the low KEY_CHARS bytes; higher bytes are dropped.
  always_comb begin
    for (int i = 0; i < KEY_CHARS; i++) begin
      if (key_i[8*i +: 8] >= LOWER_A && key_i[8*i +: 8] <= LOWER_Z) begin
        key_fold[8*i +: 8] = key_i[8*i +: 8] - CASE_DIFF;
      end else begin
        key_fold[8*i +: 8] = key_i[8*i +: 8];
      end
    end
  end

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign size_wr = cfg_wr && (cfg_idx == REG_CACHE_SIZE);

  always_comb begin
    case (cfg_idx)
      REG_CACHE_SIZE: prdata = DATA_W'(cache_size_q);
      REG_HIT_COST:   prdata = DATA_W'(hit_cost_q);
      REG_MISS_COST:  prdata = DATA_W'(miss_cost_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_size_q <= CACHE_SIZE_RST;
      hit_cost_q   <= HIT_COST_RST;
      miss_cost_q  <= MISS_COST_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CACHE_SIZE: cache_size_q <= pwdata[SIZE_W-1:0];
        REG_HIT_COST:   hit_cost_q   <= pwdata[COST_W-1:0];
        REG_MISS_COST:  miss_cost_q  <= pwdata[COST_W-1:0];
        default:        ;
      endcase
    end
  end

  // Effective sizes: a size above CAPACITY acts as CAPACITY.
  always_comb begin
    size_ext = EXT_W'(cache_size_q);
    new_ext  = EXT_W'(pwdata[SIZE_W-1:0]);
    eff      = (size_ext > EXT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(size_ext);
    eff_new  = (new_ext > EXT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(new_ext);
  end

  // Gather the rank of the matching cell; valid keys are unique, so at most one matches.
  always_comb begin
    hit_rank = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      hit_rank = hit_rank | rank_vec[j];
    end
  end

  assign hit_any = (|match_vec) && (eff != '0);
  assign fire    = (state_q == ST_LOOKUP) && !(out_valid_q && out_stall_i);

  // Command for the chain and the rank bound that goes with it.
  always_comb begin
    ctrl.upd        = fire && (eff != '0);
    ctrl.sel_hit    = hit_any;
    ctrl.sel_free   = !hit_any && (cnt_q < eff);
    ctrl.sel_victim = !hit_any && (cnt_q >= eff);
    ctrl.shrink     = size_wr;
    if (size_wr) begin
      bound = eff_new;
    end else if (hit_any) begin
      bound = CNT_W'(hit_rank);
    end else if (cnt_q < eff) begin
      bound = cnt_q;
    end else begin
      bound = cnt_q - 1'b1;
    end
  end

  // Valid entry count: grows on a fill, clips on a shrink.
  always_comb begin
    cnt_d = cnt_q;
    if (size_wr) begin
      if (cnt_q > eff_new) begin
        cnt_d = eff_new;
      end
    end else if (ctrl.upd && ctrl.sel_free) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Saturating cost accumulation.
  assign cost_add  = hit_any ? hit_cost_q : miss_cost_q;
  assign cost_sum  = {1'b0, cost_q} + (TOTAL_W + 1)'(cost_add);
  assign cost_next = cost_sum[TOTAL_W] ? '1 : cost_sum[TOTAL_W-1:0];

  // The cell chain.
  assign free_chain[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lruc_cell #(
      .KW     (KW),
      .RANK_W (RANK_W),
      .CNT_W  (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .key_i   (key_q),
      .bound_i (bound),
      .free_i  (free_chain[g]),
      .free_o  (free_chain[g+1]),
      .match_o (match_vec[g]),
      .rank_o  (rank_vec[g])
    );
  end

  // Sequencer, result register and running total.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      cost_q      <= '0;
      cnt_q       <= '0;
    end else begin
      cnt_q <= cnt_d;
      // A new result replaces the old one; otherwise a taken result is cleared.
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (fire) begin
            state_q <= ST_IDLE;
            hit_q   <= hit_any;
            cost_q  <= cost_next;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The folded key is held for the lookup cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      key_q <= key_fold;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign total_cost_o = cost_q;

endmodule

// ===== verif/lru_cache_hit_cost_counter_tb.sv =====
// Self-checking testbench for the LRU cache cost counter, with its own cache predictor.
`timescale 1ns / 100ps

module lru_cache_hit_cost_counter_tb;
  import lruc_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int KEY_CHARS    = KEY_CHARS_DEF;
  localparam int SEGMENTS     = 6;
  localparam int SEG_ITEMS    = 66;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_e;

  // One row of the directed stimulus: either a lookup or a register write.
  typedef struct packed {
    row_kind_e          kind;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   data;
    logic               known;
    logic               exp_hit;
    logic [TOTAL_W-1:0] exp_total;
  } dir_row_t;

  typedef struct packed {
    logic               hit;
    logic [TOTAL_W-1:0] total;
  } lookup_result_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [KEY_W-1:0]   key_i        = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic               hit_o;
  logic [TOTAL_W-1:0] total_cost_o;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [ADDR_W-1:0]  paddr        = '0;
  logic [DATA_W-1:0]  pwdata       = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // Predicted cache contents and register copies.
  logic [KEY_W-1:0]   cache_key   [CAPACITY];
  logic               cache_valid [CAPACITY];
  int unsigned        cache_rank  [CAPACITY];
  logic [TOTAL_W-1:0] cost_total;
  logic [SIZE_W-1:0]  size_reg;
  logic [COST_W-1:0]  hit_cost_reg;
  logic [COST_W-1:0]  miss_cost_reg;

  lookup_result_t     expected_lookups[$];
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  int                 mismatches     = 0;
  int                 lookups_seen   = 0;
  int                 hits_seen      = 0;
  int                 reg_writes     = 0;
  int                 cycles         = 0;

  lru_cache_hit_cost_counter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .total_cost_o (total_cost_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Lower-case letters become upper case; bytes beyond the key length read as zero.
  function automatic logic [KEY_W-1:0] fold_case(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] folded;
    logic [7:0]       ch;
    folded = '0;
    for (int b = 0; b < KEY_CHARS; b++) begin
      ch = raw[8*b +: 8];
      if (ch >= LOWER_A && ch <= LOWER_Z) ch = ch - CASE_DIFF;
      folded[8*b +: 8] = ch;
    end
    return folded;
  endfunction

  function automatic int unsigned entries_in_use();
    return (size_reg > CAPACITY) ? CAPACITY : size_reg;
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] sum,
                                                 input logic [COST_W-1:0] cost);
    logic [TOTAL_W:0] wide;
    wide = {1'b0, sum} + cost;
    return wide[TOTAL_W] ? '1 : wide[TOTAL_W-1:0];
  endfunction

  // Runs one lookup on the predicted cache and returns the result it must produce.
  function automatic lookup_result_t predict_lookup(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] k;
    int unsigned      used;
    int unsigned      found_rank;
    int unsigned      top_rank;
    int               hit_at;
    int               slot;
    lookup_result_t   res;
    k        = fold_case(raw);
    used     = 0;
    hit_at   = -1;
    slot     = -1;
    top_rank = 0;
    res.hit  = 1'b0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (cache_valid[j]) begin
        used++;
        if (hit_at < 0 && cache_key[j] == k) hit_at = j;
      end
    end
    if (entries_in_use() == 0) begin
      cost_total = sat_add(cost_total, miss_cost_reg);
    end else if (hit_at >= 0) begin
      // Everything more recent than the hit entry ages by one.
      found_rank = cache_rank[hit_at];
      for (int j = 0; j < CAPACITY; j++)
        if (cache_valid[j] && cache_rank[j] < found_rank) cache_rank[j]++;
      cache_rank[hit_at] = 0;
      res.hit = 1'b1;
      cost_total = sat_add(cost_total, hit_cost_reg);
    end else begin
      // Fill the lowest free entry, or else replace the least recent one.
      if (used < entries_in_use()) begin
        for (int j = CAPACITY - 1; j >= 0; j--)
          if (!cache_valid[j]) slot = j;
      end else begin
        for (int j = 0; j < CAPACITY; j++)
          if (cache_valid[j] && (slot < 0 || cache_rank[j] > top_rank)) begin
            slot     = j;
            top_rank = cache_rank[j];
          end
      end
      if (slot >= 0) begin
        for (int j = 0; j < CAPACITY; j++)
          if (cache_valid[j] && j != slot) cache_rank[j]++;
        cache_key[slot]   = k;
        cache_valid[slot] = 1'b1;
        cache_rank[slot]  = 0;
      end
      cost_total = sat_add(cost_total, miss_cost_reg);
    end
    res.total = cost_total;
    return res;
  endfunction

  function automatic void report_mismatch(input string what, input logic [KEY_W-1:0] want,
                                          input logic [KEY_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %0d at cycle %0d on %s: expected %h, got %h",
               mismatches, cycles, what, want, got);
  endfunction

  // Writes a register over APB, updates the predictor and reads the value back.
  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    want = '0;
    case (idx)
      REG_CACHE_SIZE: begin
        size_reg = value[SIZE_W-1:0];
        want[SIZE_W-1:0] = size_reg;
        // Shrinking keeps only the most recent entries.
        for (int j = 0; j < CAPACITY; j++)
          if (cache_valid[j] && cache_rank[j] >= entries_in_use()) cache_valid[j] = 1'b0;
      end
      REG_HIT_COST: begin
        hit_cost_reg = value[COST_W-1:0];
        want[COST_W-1:0] = hit_cost_reg;
      end
      REG_MISS_COST: begin
        miss_cost_reg = value[COST_W-1:0];
        want[COST_W-1:0] = miss_cost_reg;
      end
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) report_mismatch("register readback", KEY_W'(want), KEY_W'(prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offers one key, entered and left at a falling edge; may idle first.
  task automatic send_item(input logic [KEY_W-1:0] key, input logic use_typed,
                           input lookup_result_t typed);
    lookup_result_t res;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_i      <= key;
    do @(posedge clk_i); while (in_stall_o);
    res = predict_lookup(key);
    expected_lookups.push_back(use_typed ? typed : res);
    @(negedge clk_i);
  endtask

  // Waits until every expected result has come, then lets the pipeline settle.
  task automatic wait_idle();
    while (expected_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      lookups_seen++;
      if (hit_o === 1'b1) hits_seen++;
      if (expected_lookups.size() == 0) begin
        report_mismatch("result with nothing expected", '0, KEY_W'({hit_o, total_cost_o}));
      end else begin
        want = expected_lookups.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", KEY_W'(want.hit), KEY_W'(hit_o));
        if (total_cost_o !== want.total)
          report_mismatch("total_cost", KEY_W'(want.total), KEY_W'(total_cost_o));
      end
    end
  end

  // Random receiver stalls.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lru_cache_hit_cost_counter test failed");
      $finish;
    end
  end

  initial begin
    dir_row_t         dir_rows[$];
    logic [KEY_W-1:0] key_pool[$];
    logic [KEY_W-1:0] key;
    logic [7:0]       ch;
    lookup_result_t   typed;
    int               pool_len;
    int               key_len;
    int unsigned      seg_size;

    for (int j = 0; j < CAPACITY; j++) begin
      cache_key[j]   = '0;
      cache_valid[j] = 1'b0;
      cache_rank[j]  = 0;
    end
    cost_total    = '0;
    size_reg      = CACHE_SIZE_RST;
    hit_cost_reg  = HIT_COST_RST;
    miss_cost_reg = MISS_COST_RST;

    // Directed rows. The first four start from the reset costs of one and five.
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h0000_0000_0063_6261, 1'b1, 1'b0, 32'd5});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h0000_0000_0043_4241, 1'b1, 1'b1, 32'd6});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h0, 1'b1, 1'b0, 32'd11});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, '1, 1'b1, 1'b0, 32'd16});
    // Letter boundaries and a non-ASCII byte that must not fold.
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h5B40_7B60_7A61_E1FF, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h5B40_7B60_5A41_E1FF, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h5B40_7B60_5A41_C1FF, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h0000_0000_0043_4241, 1'b0, 1'b0, 32'd0});
    // Caching disabled: every access misses.
    dir_rows.push_back('{ROW_CFG, REG_CACHE_SIZE, 64'd0, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h0000_0000_0043_4241, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h0000_0000_0043_4241, 1'b0, 1'b0, 32'd0});
    // Oversized cache with extreme costs.
    dir_rows.push_back('{ROW_CFG, REG_CACHE_SIZE, 64'd63, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_CFG, REG_HIT_COST, 64'd255, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_CFG, REG_MISS_COST, 64'd0, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h0000_0000_0063_6261, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h0000_0000_0063_6261, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h8000_0000_0000_0001, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h7A7A_7A7A_7A7A_7A7A, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 1'b0, 32'd0});
    // Shrink to one entry: only the most recent key stays.
    dir_rows.push_back('{ROW_CFG, REG_CACHE_SIZE, 64'd1, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h0000_0000_0063_6261, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 1'b0, 32'd0});
    // Full capacity, free hits and the largest miss cost.
    dir_rows.push_back('{ROW_CFG, REG_CACHE_SIZE, 64'd32, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_CFG, REG_HIT_COST, 64'd0, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_CFG, REG_MISS_COST, 64'd255, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h0000_0000_0000_0061, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h0000_0000_0000_0041, 1'b0, 1'b0, 32'd0});
    dir_rows.push_back('{ROW_ITEM, REG_CACHE_SIZE, 64'h0000_0000_0000_007B, 1'b0, 1'b0, 32'd0});

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, without idling.
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        in_valid_i <= 1'b0;
        wait_idle();
        write_register(dir_rows[r].idx, dir_rows[r].data[DATA_W-1:0]);
      end else begin
        typed.hit   = dir_rows[r].exp_hit;
        typed.total = dir_rows[r].exp_total;
        send_item(dir_rows[r].data, dir_rows[r].known, typed);
      end
    end

    // Random segments, each with its own settings and a pool of recurring keys.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      in_valid_i <= 1'b0;
      wait_idle();
      send_idle_pct  = (seg < 2) ? 10 : (seg < 4) ? 83 : 0;
      recv_stall_pct = (seg < 2) ? 83 : (seg < 4) ? 10 : 0;
      case (seg)
        0:       seg_size = $urandom_range(8, 2);
        1:       seg_size = 1;
        2:       seg_size = $urandom_range(63, 33);
        3:       seg_size = 0;
        4:       seg_size = 32;
        default: seg_size = $urandom_range(63, 0);
      endcase
      // Unused upper data bits are sometimes set; the size itself stays as chosen.
      write_register(REG_CACHE_SIZE,
                     {$urandom_range(3, 0) == 0 ? ($urandom() & 32'hFFFF_FFC0) : 32'd0} |
                     seg_size);
      write_register(REG_HIT_COST, (seg == 4) ? 32'd255 : $urandom_range(255, 0));
      write_register(REG_MISS_COST, (seg == 4) ? 32'd0 : $urandom_range(255, 0));

      // Pool of up to six keys more than the cache holds, so both hits and evictions can occur.
      key_pool.delete();
      pool_len = $urandom_range(entries_in_use() + 6, 1);
      for (int p = 0; p < pool_len; p++) begin
        key = '0;
        key_len = $urandom_range(KEY_CHARS, 1);
        for (int b = 0; b < key_len; b++) begin
          if ($urandom_range(4, 0) != 0) ch = 8'h41 + 8'($urandom_range(25, 0));
          else ch = 8'($urandom_range(255, 1));
          key[8*b +: 8] = ch;
        end
        key_pool.push_back(key);
      end

      for (int i = 0; i < SEG_ITEMS; i++) begin
        if ($urandom_range(99, 0) < 15) begin
          key = {$urandom(), $urandom()};
        end else begin
          // Recurring key with the case of each letter chosen at random.
          key = key_pool[$urandom_range(pool_len - 1, 0)];
          for (int b = 0; b < KEY_CHARS; b++) begin
            ch = key[8*b +: 8];
            if (fold_case({56'd0, ch}) != {56'd0, ch} || (ch >= 8'h41 && ch <= 8'h5A))
              key[8*b +: 8] = ch ^ ($urandom_range(1, 0) ? CASE_DIFF : 8'h00);
          end
        end
        send_item(key, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    wait_idle();
    $display("Checked %0d lookups (%0d hits) across %0d register writes,",
             lookups_seen, hits_seen, reg_writes);
    $display("including disabled, single-entry, full and oversized caches and cost extremes.");
    if (mismatches == 0) begin
      $display("lru_cache_hit_cost_counter test passed");
    end else begin
      $display("lru_cache_hit_cost_counter test failed");
    end
    $finish;
  end

endmodule
